// ----- hdl/tpl_pkg.sv -----
`default_nettype none

package tpl_pkg;

  // Default store depth (taps per phase).
  localparam int SLOTS_DEF = 64;

  // Field widths.
  localparam int TIME_W   = 16;
  localparam int SAMPLE_W = 8;
  localparam int REQ_W    = 3;
  localparam int THR_W    = 7;
  localparam int COUNT_W  = 7;

  // Configuration register indexes and reset values.
  localparam logic [1:0] REG_TAP_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_HOLDOFF_UNITS   = 2'd1;
  localparam logic [1:0] REG_MATCH_TOLERANCE = 2'd2;

  localparam logic [THR_W-1:0]  TAP_THRESHOLD_RST   = 7'd3;
  localparam logic [TIME_W-1:0] HOLDOFF_UNITS_RST   = 16'd10;
  localparam logic [TIME_W-1:0] MATCH_TOLERANCE_RST = 16'd100;

  // Request codes on the input side.
  typedef enum logic [REQ_W-1:0] {
    REQ_START_RECORD  = 3'd0,
    REQ_RECORD_SAMPLE = 3'd1,
    REQ_START_ATTEMPT = 3'd2,
    REQ_ATTEMPT_SAMPLE = 3'd3,
    REQ_CHECK         = 3'd4
  } req_t;

  // Classified command passed from the front end to the back end.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_TAP_REF,
    CMD_TAP_ATT,
    CMD_CHECK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [TIME_W-1:0] time_units;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic               tap_seen;
    logic [TIME_W-1:0]  tap_time;
    logic [COUNT_W-1:0] slot_index;
    logic               check_done;
    logic               all_match;
    logic [COUNT_W-1:0] match_count;
    logic               led_on;
  } result_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ----- hdl/tpl_front.sv -----
`default_nettype none

module tpl_front
  import tpl_pkg::*;
(
  input  wire logic [REQ_W-1:0]    req_type,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic [TIME_W-1:0]   time_units,
  input  wire logic [THR_W-1:0]    tap_threshold,
  output cmd_t                     cmd
);

  logic [SAMPLE_W-1:0] mag;
  logic                above;

  // Magnitude of the signed sample; the most negative value maps to 128.
  assign mag   = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
  assign above = mag > {1'b0, tap_threshold};

  // Sort the request into what the back end has to do. A sample that is not
  // loud enough changes nothing and only reports the state.
  always_comb begin
    cmd.time_units = time_units;
    unique case (req_type)
      REQ_START_RECORD, REQ_START_ATTEMPT: cmd.kind = CMD_START;
      REQ_RECORD_SAMPLE:  cmd.kind = above ? CMD_TAP_REF : CMD_NONE;
      REQ_ATTEMPT_SAMPLE: cmd.kind = above ? CMD_TAP_ATT : CMD_NONE;
      REQ_CHECK:          cmd.kind = CMD_CHECK;
      default:            cmd.kind = CMD_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/tpl_queue.sv -----
`default_nettype none

module tpl_queue
  import tpl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head
);

  cmd_t       entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;

  assign full      = fill == 2'd2;
  assign not_empty = fill != 2'd0;
  assign head      = entry[rp];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tpl_back.sv -----
`default_nettype none

module tpl_back
  import tpl_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [TIME_W-1:0] holdoff_units,
  input  wire logic [TIME_W-1:0] match_tolerance,
  input  wire logic              q_valid,
  input  wire cmd_t              q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output result_t                out_res
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  back_state_t state, state_next;

  // Tap stores and their valid bits; an entry never written reads as zero.
  logic [TIME_W-1:0] ref_mem [SLOTS];
  logic [TIME_W-1:0] att_mem [SLOTS];
  logic [SLOTS-1:0]  ref_vld;
  logic [SLOTS-1:0]  att_vld;

  logic [CW-1:0]     write_slot;
  logic [TIME_W-1:0] last_tap_time;
  logic              holdoff_armed;
  logic              led_state;

  logic [AW-1:0]     rd_addr;
  logic [TIME_W-1:0] ref_q;
  logic [TIME_W-1:0] att_q;
  logic              ref_ok;
  logic              att_ok;
  logic              cmp_vld;
  logic [CW-1:0]     match_cnt;

  logic              out_free;
  logic              is_tap;
  logic              in_holdoff;
  logic              tap_ok;
  logic              wr_ref;
  logic              wr_att;
  logic              issue;
  logic              start_check;
  logic              load_simple;
  logic              load_check;
  logic              all_ok;
  logic [CW-1:0]     slot_new;
  logic [CW+COUNT_W-1:0] slot_ext;
  logic [CW+COUNT_W-1:0] wslot_ext;
  logic [CW+COUNT_W-1:0] count_ext;
  logic [TIME_W:0]   holdoff_end;
  logic [TIME_W-1:0] cmp_a;
  logic [TIME_W-1:0] cmp_b;
  logic [TIME_W-1:0] cmp_d;
  logic              cmp_hit;

  assign out_free = !out_valid || out_ready;

  // Tap acceptance: hold-off window (no wrap) and a full store block it.
  assign is_tap      = (q_head.kind == CMD_TAP_REF) || (q_head.kind == CMD_TAP_ATT);
  assign holdoff_end = {1'b0, last_tap_time} + {1'b0, holdoff_units};
  assign in_holdoff  = holdoff_armed && ({1'b0, q_head.time_units} < holdoff_end);
  assign tap_ok      = is_tap && !in_holdoff && (write_slot != CW'(SLOTS));

  // Slot count after a simple command.
  always_comb begin
    priority if (q_head.kind == CMD_START) begin
      slot_new = '0;
    end else if (tap_ok) begin
      slot_new = write_slot + 1'b1;
    end else begin
      slot_new = write_slot;
    end
  end

  // A check reports the slot count as it stands; the queue head by then
  // already belongs to the next item.
  assign slot_ext  = {{COUNT_W{1'b0}}, slot_new};
  assign wslot_ext = {{COUNT_W{1'b0}}, write_slot};
  assign count_ext = {{COUNT_W{1'b0}}, match_cnt};
  assign all_ok    = match_cnt == CW'(SLOTS);

  // Compare stage of the slot walk.
  assign cmp_a   = ref_ok ? ref_q : '0;
  assign cmp_b   = att_ok ? att_q : '0;
  assign cmp_d   = (cmp_a >= cmp_b) ? (cmp_a - cmp_b) : (cmp_b - cmp_a);
  assign cmp_hit = cmp_d <= match_tolerance;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && out_free && q_head.kind == CMD_CHECK) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_addr == AW'(SLOTS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    q_pop       = 1'b0;
    load_simple = 1'b0;
    start_check = 1'b0;
    issue       = 1'b0;
    load_check  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_head.kind == CMD_CHECK) begin
            start_check = 1'b1;
          end else begin
            load_simple = 1'b1;
          end
        end
      end
      ST_WALK:  issue = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  load_check = out_free;
      default: ;
    endcase
  end

  assign wr_ref = load_simple && tap_ok && (q_head.kind == CMD_TAP_REF);
  assign wr_att = load_simple && tap_ok && (q_head.kind == CMD_TAP_ATT);

  // Store writes and registered reads for the walk.
  always_ff @(posedge clk) begin
    if (wr_ref) begin
      ref_mem[write_slot[AW-1:0]] <= q_head.time_units;
    end
    if (wr_att) begin
      att_mem[write_slot[AW-1:0]] <= q_head.time_units;
    end
    if (issue) begin
      ref_q  <= ref_mem[rd_addr];
      att_q  <= att_mem[rd_addr];
      ref_ok <= ref_vld[rd_addr];
      att_ok <= att_vld[rd_addr];
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load_simple) begin
      out_res.tap_seen    <= tap_ok;
      out_res.tap_time    <= tap_ok ? q_head.time_units : '0;
      out_res.slot_index  <= slot_ext[COUNT_W-1:0];
      out_res.check_done  <= 1'b0;
      out_res.all_match   <= 1'b0;
      out_res.match_count <= '0;
      out_res.led_on      <= led_state;
    end else if (load_check) begin
      out_res.tap_seen    <= 1'b0;
      out_res.tap_time    <= '0;
      out_res.slot_index  <= wslot_ext[COUNT_W-1:0];
      out_res.check_done  <= 1'b1;
      out_res.all_match   <= all_ok;
      out_res.match_count <= count_ext[COUNT_W-1:0];
      out_res.led_on      <= led_state ^ all_ok;
    end
  end

  // Control and phase state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ref_vld       <= '0;
      att_vld       <= '0;
      write_slot    <= '0;
      last_tap_time <= '0;
      holdoff_armed <= 1'b0;
      led_state     <= 1'b0;
      rd_addr       <= '0;
      cmp_vld       <= 1'b0;
      match_cnt     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= issue;

      if (load_simple) begin
        write_slot <= slot_new;
        if (q_head.kind == CMD_START) begin
          last_tap_time <= '0;
          holdoff_armed <= 1'b0;
        end else if (tap_ok) begin
          last_tap_time <= q_head.time_units;
          holdoff_armed <= 1'b1;
        end
      end
      if (wr_ref) begin
        ref_vld[write_slot[AW-1:0]] <= 1'b1;
      end
      if (wr_att) begin
        att_vld[write_slot[AW-1:0]] <= 1'b1;
      end

      // Slot walk.
      if (start_check) begin
        rd_addr   <= '0;
        match_cnt <= '0;
      end else if (issue) begin
        rd_addr <= rd_addr + 1'b1;
      end
      if (cmp_vld) begin
        match_cnt <= match_cnt + CW'(cmp_hit);
      end

      // A full match toggles the LED and empties the attempt store.
      if (load_check && all_ok) begin
        led_state <= ~led_state;
        att_vld   <= '0;
      end

      if (load_simple || load_check) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The write slot saturates at the store depth.
  assert property (@(posedge clk) disable iff (rst) write_slot <= CW'(SLOTS))
    else $error("write slot beyond store depth");

  // A full match leaves the attempt store empty.
  assert property (@(posedge clk) disable iff (rst)
    (load_check && all_ok) |=> (att_vld == '0))
    else $error("attempt store not cleared after full match");

  // The LED only changes when a check is reported.
  assert property (@(posedge clk) disable iff (rst)
    (led_state != $past(led_state)) |-> $past(load_check))
    else $error("LED changed outside a check report");

  // No compare result may still be in flight when a check is reported.
  assert property (@(posedge clk) disable iff (rst) load_check |-> !cmp_vld)
    else $error("check reported before the walk finished");

endmodule

`default_nettype wire

// ----- hdl/tap_pattern_lock_core.sv -----
`default_nettype none

// Tap-pattern lock. Each input item is a request (start record, record
// sample, start attempt, attempt sample, check); every item gives exactly one
// result item. A sample louder than tap_threshold, outside the hold-off window
// of the previous tap and with room left in the store, is stored as a tap in
// the reference or attempt store. Start, sample and unused requests need no
// walk, so with a free output they flow at one item per cycle after a
// two-entry command queue. A check walks both stores one slot per cycle
// through their single read ports, then drains the last compare before its
// result is offered; a full match toggles the LED and empties the attempt
// store at once. Both stores read as zero after reset through per-entry valid
// bits, so no clearing pass is needed. The user must write configuration
// through the cfg port only while no item is in flight, which is not enforced.
module tap_pattern_lock_core
  import tpl_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // Request stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // sample[7:0], time_units[23:8]
  input  wire logic [2:0]  s_tuser,   // req_type[2:0]
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // tap_seen[0], tap_time[16:1], slot_index[23:17],
                                      // all_match[24], match_count[31:25], led_on[32], zero
  output logic             m_tuser    // check_done
);

  logic [THR_W-1:0]  tap_threshold;
  logic [TIME_W-1:0] holdoff_units;
  logic [TIME_W-1:0] match_tolerance;

  cmd_t    front_cmd;
  cmd_t    q_head;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  logic    push;
  result_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_threshold   <= TAP_THRESHOLD_RST;
      holdoff_units   <= HOLDOFF_UNITS_RST;
      match_tolerance <= MATCH_TOLERANCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAP_THRESHOLD:   tap_threshold   <= cfg_data[THR_W-1:0];
        REG_HOLDOFF_UNITS:   holdoff_units   <= cfg_data;
        REG_MATCH_TOLERANCE: match_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  tpl_front u_front (
    .req_type      (s_tuser),
    .sample        (s_tdata[7:0]),
    .time_units    (s_tdata[23:8]),
    .tap_threshold (tap_threshold),
    .cmd           (front_cmd)
  );

  tpl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tpl_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .holdoff_units   (holdoff_units),
    .match_tolerance (match_tolerance),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_res         (res)
  );

  // Result packing.
  assign m_tdata = {7'd0, res.led_on, res.match_count, res.all_match,
                    res.slot_index, res.tap_time, res.tap_seen};
  assign m_tuser = res.check_done;

endmodule

`default_nettype wire
